[sv/ppt_pkg.sv]
// ----------------------------------------------------------------------------
// ppt_pkg
// shared types and constants of the pointer position tracker
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

   // command codes
   localparam int CMD_BITS = 2;
   localparam logic [CMD_BITS-1:0] CMD_POLL       = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_TAKE_LEFT  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_TAKE_RIGHT = 2'd2;

   // payload widths
   localparam int DELTA_BITS   = 16;
   localparam int BUTTON_BITS  = 3;
   localparam int COUNT_BITS   = 16;
   localparam int OUT_POS_BITS = 10;

   // configuration registers
   localparam int MIN_BITS      = 10;
   localparam int MAX_BITS      = 11;
   localparam int CSR_DATA_BITS = 11;
   localparam int CSR_IDX_BITS  = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_X = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_Y = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_X = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_Y = 2'd3;

   // reset values
   localparam logic [MIN_BITS-1:0] MIN_X_RESET = 10'd0;
   localparam logic [MIN_BITS-1:0] MIN_Y_RESET = 10'd0;
   localparam logic [MAX_BITS-1:0] MAX_X_RESET = 11'd320;
   localparam logic [MAX_BITS-1:0] MAX_Y_RESET = 11'd200;
   localparam int CURSOR_X_RESET = 160;
   localparam int CURSOR_Y_RESET = 100;

   // clamp box of one axis
   typedef struct packed {
      logic [MIN_BITS-1:0] lo;
      logic [MAX_BITS-1:0] hi_excl;
   } bounds_type;

endpackage

`default_nettype wire

[sv/ppt_req_if.sv]
// ----------------------------------------------------------------------------
// ppt_req_if
// command channel: poll updates and press-count takes
// ----------------------------------------------------------------------------
`default_nettype none

interface ppt_req_if;

   logic                                valid;
   logic                                ready;
   logic [ppt_pkg::CMD_BITS-1:0]        command;
   logic signed [ppt_pkg::DELTA_BITS-1:0] motion_dx;
   logic signed [ppt_pkg::DELTA_BITS-1:0] motion_dy;
   logic [ppt_pkg::BUTTON_BITS-1:0]     button_bits;
   logic [ppt_pkg::COUNT_BITS-1:0]      new_left_presses;
   logic [ppt_pkg::COUNT_BITS-1:0]      new_right_presses;

   modport source (
      output valid, command, motion_dx, motion_dy, button_bits,
             new_left_presses, new_right_presses,
      input  ready
   );

   modport sink (
      input  valid, command, motion_dx, motion_dy, button_bits,
             new_left_presses, new_right_presses,
      output ready
   );

endinterface

`default_nettype wire

[sv/ppt_rsp_if.sv]
// ----------------------------------------------------------------------------
// ppt_rsp_if
// result channel: cursor, held buttons and taken press count
// ----------------------------------------------------------------------------
`default_nettype none

interface ppt_rsp_if;

   logic                              valid;
   logic                              ready;
   logic [ppt_pkg::OUT_POS_BITS-1:0]  out_x;
   logic [ppt_pkg::OUT_POS_BITS-1:0]  out_y;
   logic [ppt_pkg::BUTTON_BITS-1:0]   out_buttons;
   logic [ppt_pkg::COUNT_BITS-1:0]    presses_taken;

   modport source (
      output valid, out_x, out_y, out_buttons, presses_taken,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_buttons, presses_taken,
      output ready
   );

endinterface

`default_nettype wire

[sv/ppt_axis.sv]
// ----------------------------------------------------------------------------
// ppt_axis
// one axis: remainder add, divide by mickeys per pixel, move and clamp
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_axis #(
   parameter int MICKEYS_PER_PIXEL = 2,
   parameter int COORD_BITS        = 10,
   parameter int REM_BITS          = 2
) (
   input  wire logic [COORD_BITS-1:0]              cursor,
   input  wire logic signed [REM_BITS-1:0]         rem,
   input  wire logic signed [ppt_pkg::DELTA_BITS-1:0] delta,
   input  wire ppt_pkg::bounds_type                bounds,
   output      logic [COORD_BITS-1:0]              cursor_nx,
   output      logic signed [REM_BITS-1:0]         rem_nx
);

   import ppt_pkg::*;

   localparam int SUM_BITS   = DELTA_BITS + 1;
   localparam int MAG_BITS   = DELTA_BITS;
   // exact reciprocal for dividends below 2^MAG_BITS
   localparam int LOG_M      = $clog2(MICKEYS_PER_PIXEL);
   localparam int SHIFT      = MAG_BITS + LOG_M;
   localparam int RECIP      = ((1 << SHIFT) + MICKEYS_PER_PIXEL - 1) / MICKEYS_PER_PIXEL;
   localparam int RECIP_BITS = $clog2(RECIP + 1);
   localparam int PROD_BITS  = MAG_BITS + RECIP_BITS;
   localparam int POS_BITS   = ((COORD_BITS > MAG_BITS) ? COORD_BITS : MAG_BITS) + 2;
   localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

   logic signed [SUM_BITS-1:0]  sum;
   logic                        neg;
   logic [MAG_BITS-1:0]         mag;
   logic [PROD_BITS-1:0]        prod;
   logic [MAG_BITS-1:0]         quot;
   logic [REM_BITS-1:0]         rem_mag;
   logic signed [POS_BITS-1:0]  cur_ext;
   logic signed [POS_BITS-1:0]  quot_ext;
   logic signed [POS_BITS-1:0]  pos;
   logic signed [POS_BITS-1:0]  lo_ext;
   logic signed [POS_BITS-1:0]  hi_ext;
   logic signed [POS_BITS-1:0]  clamped;
   logic [MAX_BITS-1:0]         hi_raw;

   // sum and magnitude
   assign sum  = SUM_BITS'(delta) + SUM_BITS'(rem);
   assign neg  = sum[SUM_BITS-1];
   assign mag  = MAG_BITS'(neg ? -sum : sum);

   // quotient by reciprocal, remainder only needs its low bits
   assign prod    = PROD_BITS'(mag) * PROD_BITS'(RECIP);
   assign quot    = MAG_BITS'(prod >> SHIFT);
   assign rem_mag = REM_BITS'(mag) - REM_BITS'(REM_BITS'(quot) * REM_BITS'(MICKEYS_PER_PIXEL));
   assign rem_nx  = neg ? -$signed(rem_mag) : $signed(rem_mag);

   // truncated move
   assign cur_ext  = POS_BITS'(cursor);
   assign quot_ext = POS_BITS'(quot);
   assign pos      = neg ? (cur_ext - quot_ext) : (cur_ext + quot_ext);

   // upper bound: zero acts as one, capped to coordinate range
   always_comb begin
      hi_raw = (bounds.hi_excl == '0) ? '0 : bounds.hi_excl - MAX_BITS'(1);
      lo_ext = POS_BITS'(bounds.lo);
      hi_ext = POS_BITS'(hi_raw);
      if (hi_ext > POS_BITS'(COORD_MAX)) begin
         hi_ext = POS_BITS'(COORD_MAX);
      end
      clamped = pos;
      if (clamped < lo_ext) begin
         clamped = lo_ext;
      end
      // upper clamp wins
      if (clamped > hi_ext) begin
         clamped = hi_ext;
      end
   end

   assign cursor_nx = COORD_BITS'(clamped);

endmodule

`default_nettype wire

[sv/pointer_position_tracker_unit.sv]
// ----------------------------------------------------------------------------
// pointer_position_tracker_unit
// mouse cursor accumulator with sub-pixel remainder and box clamp
// ----------------------------------------------------------------------------
//
//  port     | dir | handshake        | contents
//  ---------+-----+------------------+-------------------------------------------
//  req_ch   | in  | valid / ready    | command, motion, buttons, new press counts
//  rsp_ch   | out | valid / ready    | cursor x/y, held buttons, taken count
//  csr_*    | in  | write enable     | min_x, min_y, max_x, max_y
//
//  one word per cycle while rsp_ch takes the results; a word's result is valid in the cycle after acceptance
//  the cursor and remainder update is a single pass: add, reciprocal multiply,
//  add to cursor, clamp, all between the state registers
//  a result register parts the two channels: a new word is taken while the
//  previous result waits, as long as that result leaves in the same cycle
//  synchronous active-high reset: cursor 160,100, box 0..319 by 0..199
//  a csr write re-clamps both axes in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_position_tracker_unit #(
   parameter int MICKEYS_PER_PIXEL = 2,
   parameter int COORD_BITS        = 10
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ppt_req_if.sink                                  req_ch,
   ppt_rsp_if.source                                rsp_ch,
   input  wire logic                                csr_write_en,
   input  wire logic [ppt_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [ppt_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   import ppt_pkg::*;

   localparam int REM_BITS = $clog2(MICKEYS_PER_PIXEL) + 1;

   // box registers
   logic [MIN_BITS-1:0] min_x_ff, min_x_in;
   logic [MIN_BITS-1:0] min_y_ff, min_y_in;
   logic [MAX_BITS-1:0] max_x_ff, max_x_in;
   logic [MAX_BITS-1:0] max_y_ff, max_y_in;

   // tracker state
   logic [COORD_BITS-1:0]        cursor_x_ff, cursor_y_ff;
   logic signed [REM_BITS-1:0]   rem_x_ff, rem_y_ff;
   logic [BUTTON_BITS-1:0]       held_ff;
   logic [COUNT_BITS-1:0]        left_count_ff, right_count_ff;

   // result register
   logic                         rsp_valid_ff;
   logic [OUT_POS_BITS-1:0]      rsp_x_ff, rsp_y_ff;
   logic [BUTTON_BITS-1:0]       rsp_buttons_ff;
   logic [COUNT_BITS-1:0]        rsp_taken_ff;

   logic                         req_acc;
   logic                         poll_acc;
   logic                         move_en;
   logic signed [DELTA_BITS-1:0] dx, dy;
   bounds_type                   bounds_x, bounds_y;
   logic [COORD_BITS-1:0]        cursor_x_in, cursor_y_in;
   logic signed [REM_BITS-1:0]   rem_x_in, rem_y_in;
   logic [COUNT_BITS:0]          left_sum, right_sum;
   logic [COUNT_BITS-1:0]        taken;
   logic [BUTTON_BITS-1:0]       rsp_buttons_in;

   // accept while the result slot is free or is being emptied
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign poll_acc     = req_acc && (req_ch.command == CMD_POLL);

   // box next values, so a csr write clamps against the new box at once
   always_comb begin
      min_x_in = min_x_ff;
      min_y_in = min_y_ff;
      max_x_in = max_x_ff;
      max_y_in = max_y_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_X: min_x_in = MIN_BITS'(csr_wdata);
            CSR_MIN_Y: min_y_in = MIN_BITS'(csr_wdata);
            CSR_MAX_X: max_x_in = csr_wdata;
            CSR_MAX_Y: max_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign bounds_x = '{lo: min_x_in, hi_excl: max_x_in};
   assign bounds_y = '{lo: min_y_in, hi_excl: max_y_in};

   // zero motion leaves the remainder alone and only re-clamps
   assign dx      = poll_acc ? req_ch.motion_dx : '0;
   assign dy      = poll_acc ? req_ch.motion_dy : '0;
   assign move_en = poll_acc || csr_write_en;

   ppt_axis #(
      .MICKEYS_PER_PIXEL (MICKEYS_PER_PIXEL),
      .COORD_BITS        (COORD_BITS),
      .REM_BITS          (REM_BITS)
   ) u_axis_x (
      .cursor    (cursor_x_ff),
      .rem       (rem_x_ff),
      .delta     (dx),
      .bounds    (bounds_x),
      .cursor_nx (cursor_x_in),
      .rem_nx    (rem_x_in)
   );

   ppt_axis #(
      .MICKEYS_PER_PIXEL (MICKEYS_PER_PIXEL),
      .COORD_BITS        (COORD_BITS),
      .REM_BITS          (REM_BITS)
   ) u_axis_y (
      .cursor    (cursor_y_ff),
      .rem       (rem_y_ff),
      .delta     (dy),
      .bounds    (bounds_y),
      .cursor_nx (cursor_y_in),
      .rem_nx    (rem_y_in)
   );

   // saturating press counters
   assign left_sum  = (COUNT_BITS + 1)'(left_count_ff) + (COUNT_BITS + 1)'(req_ch.new_left_presses);
   assign right_sum = (COUNT_BITS + 1)'(right_count_ff) + (COUNT_BITS + 1)'(req_ch.new_right_presses);

   // taken count and reported buttons
   always_comb begin
      case (req_ch.command)
         CMD_TAKE_LEFT:  taken = left_count_ff;
         CMD_TAKE_RIGHT: taken = right_count_ff;
         default:        taken = '0;
      endcase
   end

   assign rsp_buttons_in = (req_ch.command == CMD_POLL) ? req_ch.button_bits : held_ff;

   // state
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff       <= MIN_X_RESET;
         min_y_ff       <= MIN_Y_RESET;
         max_x_ff       <= MAX_X_RESET;
         max_y_ff       <= MAX_Y_RESET;
         cursor_x_ff    <= COORD_BITS'(CURSOR_X_RESET);
         cursor_y_ff    <= COORD_BITS'(CURSOR_Y_RESET);
         rem_x_ff       <= '0;
         rem_y_ff       <= '0;
         held_ff        <= '0;
         left_count_ff  <= '0;
         right_count_ff <= '0;
      end else begin
         min_x_ff <= min_x_in;
         min_y_ff <= min_y_in;
         max_x_ff <= max_x_in;
         max_y_ff <= max_y_in;
         if (move_en) begin
            cursor_x_ff <= cursor_x_in;
            cursor_y_ff <= cursor_y_in;
            rem_x_ff    <= rem_x_in;
            rem_y_ff    <= rem_y_in;
         end
         if (poll_acc) begin
            held_ff        <= req_ch.button_bits;
            left_count_ff  <= left_sum[COUNT_BITS] ? '1 : left_sum[COUNT_BITS-1:0];
            right_count_ff <= right_sum[COUNT_BITS] ? '1 : right_sum[COUNT_BITS-1:0];
         end
         if (req_acc && (req_ch.command == CMD_TAKE_LEFT)) begin
            left_count_ff <= '0;
         end
         if (req_acc && (req_ch.command == CMD_TAKE_RIGHT)) begin
            right_count_ff <= '0;
         end
      end
   end

   // result slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_x_ff       <= OUT_POS_BITS'(cursor_x_in);
         rsp_y_ff       <= OUT_POS_BITS'(cursor_y_in);
         rsp_buttons_ff <= rsp_buttons_in;
         rsp_taken_ff   <= taken;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_x         = rsp_x_ff;
   assign rsp_ch.out_y         = rsp_y_ff;
   assign rsp_ch.out_buttons   = rsp_buttons_ff;
   assign rsp_ch.presses_taken = rsp_taken_ff;

   // every accepted word leaves a result behind it
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   // a left take returns the old count and clears it
   a_take_left: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_ch.command == CMD_TAKE_LEFT)) |=>
      ((left_count_ff == '0) && (rsp_taken_ff == $past(left_count_ff))))
      else $error("left take did not return and clear the count");

   // polls report no taken presses
   a_poll_zero_taken: assert property (@(posedge clock) disable iff (reset)
      poll_acc |=> (rsp_taken_ff == '0))
      else $error("poll reported a non-zero taken count");

   // cursor and remainder hold without a poll or a box write
   a_cursor_holds: assert property (@(posedge clock) disable iff (reset)
      !move_en |=> ($stable(cursor_x_ff) && $stable(cursor_y_ff) &&
                    $stable(rem_x_ff) && $stable(rem_y_ff)))
      else $error("cursor moved without a poll or box write");

endmodule

`default_nettype wire
